/* rtl/spief_pkg.sv */
// Shared types, codes and the sequencer program of the SPI engine command framer.
`timescale 1ns / 1ps
package spief_pkg;

    localparam int CLK_W = 25;
    localparam int LEN_W = 25;
    localparam int PC_W  = 5;

    localparam logic [CLK_W-1:0] CLK_BASE = 25'd6000000;
    localparam logic [CLK_W-1:0] CLK_FAST = 25'd30000000;

    // Engine opcodes and port layout
    localparam logic [7:0] CMD_SET_PORT  = 8'h80;
    localparam logic [7:0] CMD_PORT_DIR  = 8'hFB;
    localparam logic [7:0] CMD_WRITE     = 8'h31;
    localparam logic [7:0] CMD_DIVISOR   = 8'h86;
    localparam logic [7:0] CMD_PRESC_ON  = 8'h8B;
    localparam logic [7:0] CMD_PRESC_OFF = 8'h8A;
    localparam logic [7:0] CMD_LOOP_OFF  = 8'h85;
    localparam logic [7:0] PORT_IDLE     = 8'hF0;

    // Request function codes
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_DATA  = 2'd1;
    localparam logic [1:0] FUNC_SETUP = 2'd2;
    localparam logic [1:0] FUNC_PORT  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NOTX = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;
    localparam logic [1:0] ST_ZERO = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_CLOCK_HZ = 2'd0;
    localparam logic [1:0] CFG_SPI_MODE = 2'd1;
    localparam logic [1:0] CFG_TMS_HIGH = 2'd2;

    typedef struct packed {
        logic [1:0]       func;
        logic [1:0]       cs_select;
        logic [LEN_W-1:0] transfer_length;
        logic [7:0]       data_byte;
    } t_req;

    typedef struct packed {
        logic [7:0] cmd_byte;
        logic       end_of_run;
        logic       end_of_buffer;
        logic [1:0] status;
    } t_rsp;

    typedef enum logic [3:0] {
        SRC_CONST,
        SRC_DATA,
        SRC_PORT,
        SRC_HDR_LO,
        SRC_HDR_HI,
        SRC_CLKCMD,
        SRC_DIV_LO,
        SRC_DIV_HI
    } t_src;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_START,
        OP_PAY,
        OP_DIV
    } t_op;

    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_ALWAYS,
        JMP_CLK_ZERO,
        JMP_DIV_BUSY
    } t_jmp;

    typedef struct packed {
        logic            emit;
        t_src            src;
        logic [7:0]      konst;
        logic            eob;
        logic            last;
        logic [1:0]      status;
        t_op             op;
        t_jmp            jmp;
        logic [PC_W-1:0] target;
    } t_uword;

    // Program entry points and labels
    localparam logic [PC_W-1:0] PC_ERR_NOTX   = 5'd0;
    localparam logic [PC_W-1:0] PC_ERR_BUSY   = 5'd1;
    localparam logic [PC_W-1:0] PC_ERR_ZERO   = 5'd2;
    localparam logic [PC_W-1:0] PC_START      = 5'd3;
    localparam logic [PC_W-1:0] PC_START_PORT = 5'd4;
    localparam logic [PC_W-1:0] PC_START_DIR  = 5'd5;
    localparam logic [PC_W-1:0] PC_HDR        = 5'd6;
    localparam logic [PC_W-1:0] PC_HDR_LO     = 5'd7;
    localparam logic [PC_W-1:0] PC_HDR_HI     = 5'd8;
    localparam logic [PC_W-1:0] PC_PAY_MID    = 5'd9;
    localparam logic [PC_W-1:0] PC_PAY_CHUNK  = 5'd10;
    localparam logic [PC_W-1:0] PC_PAY_CLOSE  = 5'd11;
    localparam logic [PC_W-1:0] PC_CLOSE_SET  = 5'd12;
    localparam logic [PC_W-1:0] PC_CLOSE_PORT = 5'd13;
    localparam logic [PC_W-1:0] PC_CLOSE_DIR  = 5'd14;
    localparam logic [PC_W-1:0] PC_SETUP      = 5'd15;
    localparam logic [PC_W-1:0] PC_DIV_WAIT   = 5'd16;
    localparam logic [PC_W-1:0] PC_CLKCMD     = 5'd17;
    localparam logic [PC_W-1:0] PC_DIVCMD     = 5'd18;
    localparam logic [PC_W-1:0] PC_DIV_LO     = 5'd19;
    localparam logic [PC_W-1:0] PC_DIV_HI     = 5'd20;
    localparam logic [PC_W-1:0] PC_PORT_SETUP = 5'd21;
    localparam logic [PC_W-1:0] PC_SETUP_PORT = 5'd22;
    localparam logic [PC_W-1:0] PC_SETUP_DIR  = 5'd23;
    localparam logic [PC_W-1:0] PC_LOOP_OFF   = 5'd24;

    function automatic t_uword f_uw(input logic emit, input t_src src, input logic [7:0] konst,
                                    input logic eob, input logic last, input logic [1:0] status,
                                    input t_op op, input t_jmp jmp,
                                    input logic [PC_W-1:0] target);
        t_uword w;
        w.emit   = emit;
        w.src    = src;
        w.konst  = konst;
        w.eob    = eob;
        w.last   = last;
        w.status = status;
        w.op     = op;
        w.jmp    = jmp;
        w.target = target;
        return w;
    endfunction

    function automatic t_uword f_rom(input logic [PC_W-1:0] a);
        t_uword w;
        case (a)
            PC_ERR_NOTX:   w = f_uw(1'b1, SRC_CONST, 8'h00, 1'b0, 1'b1, ST_NOTX, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_ERR_BUSY:   w = f_uw(1'b1, SRC_CONST, 8'h00, 1'b0, 1'b1, ST_BUSY, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_ERR_ZERO:   w = f_uw(1'b1, SRC_CONST, 8'h00, 1'b0, 1'b1, ST_ZERO, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_START:      w = f_uw(1'b1, SRC_CONST, CMD_SET_PORT, 1'b0, 1'b0, ST_OK, OP_START,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_START_PORT: w = f_uw(1'b1, SRC_PORT, 8'h00, 1'b0, 1'b0, ST_OK, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_START_DIR:  w = f_uw(1'b1, SRC_CONST, CMD_PORT_DIR, 1'b0, 1'b0, ST_OK, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_HDR:        w = f_uw(1'b1, SRC_CONST, CMD_WRITE, 1'b0, 1'b0, ST_OK, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_HDR_LO:     w = f_uw(1'b1, SRC_HDR_LO, 8'h00, 1'b0, 1'b0, ST_OK, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_HDR_HI:     w = f_uw(1'b1, SRC_HDR_HI, 8'h00, 1'b0, 1'b1, ST_OK, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_PAY_MID:    w = f_uw(1'b1, SRC_DATA, 8'h00, 1'b0, 1'b1, ST_OK, OP_PAY,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_PAY_CHUNK:  w = f_uw(1'b1, SRC_DATA, 8'h00, 1'b1, 1'b0, ST_OK, OP_PAY,
                                    JMP_ALWAYS, PC_HDR);
            PC_PAY_CLOSE:  w = f_uw(1'b1, SRC_DATA, 8'h00, 1'b0, 1'b0, ST_OK, OP_PAY,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_CLOSE_SET:  w = f_uw(1'b1, SRC_CONST, CMD_SET_PORT, 1'b0, 1'b0, ST_OK, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_CLOSE_PORT: w = f_uw(1'b1, SRC_PORT, 8'h00, 1'b0, 1'b0, ST_OK, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_CLOSE_DIR:  w = f_uw(1'b1, SRC_CONST, CMD_PORT_DIR, 1'b1, 1'b1, ST_OK, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_SETUP:      w = f_uw(1'b0, SRC_CONST, 8'h00, 1'b0, 1'b0, ST_OK, OP_DIV,
                                    JMP_CLK_ZERO, PC_PORT_SETUP);
            PC_DIV_WAIT:   w = f_uw(1'b0, SRC_CONST, 8'h00, 1'b0, 1'b0, ST_OK, OP_NONE,
                                    JMP_DIV_BUSY, PC_DIV_WAIT);
            PC_CLKCMD:     w = f_uw(1'b1, SRC_CLKCMD, 8'h00, 1'b0, 1'b0, ST_OK, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_DIVCMD:     w = f_uw(1'b1, SRC_CONST, CMD_DIVISOR, 1'b0, 1'b0, ST_OK, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_DIV_LO:     w = f_uw(1'b1, SRC_DIV_LO, 8'h00, 1'b0, 1'b0, ST_OK, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_DIV_HI:     w = f_uw(1'b1, SRC_DIV_HI, 8'h00, 1'b0, 1'b0, ST_OK, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_PORT_SETUP: w = f_uw(1'b1, SRC_CONST, CMD_SET_PORT, 1'b0, 1'b0, ST_OK, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_SETUP_PORT: w = f_uw(1'b1, SRC_PORT, 8'h00, 1'b0, 1'b0, ST_OK, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_SETUP_DIR:  w = f_uw(1'b1, SRC_CONST, CMD_PORT_DIR, 1'b0, 1'b0, ST_OK, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
            PC_LOOP_OFF:   w = f_uw(1'b1, SRC_CONST, CMD_LOOP_OFF, 1'b1, 1'b1, ST_OK, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
            default:       w = f_uw(1'b0, SRC_CONST, 8'h00, 1'b0, 1'b1, ST_OK, OP_NONE,
                                    JMP_NONE, PC_ERR_NOTX);
        endcase
        return w;
    endfunction

endpackage

/* rtl/spief_stream_if.sv */
// Valid/ready stream interface carrying one request or response.
`timescale 1ns / 1ps
interface spief_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/spief_div.sv */
// Restoring divider, one quotient bit per cycle, for the clock divider value.
`timescale 1ns / 1ps
module spief_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [spief_pkg::CLK_W-1:0]   i_dividend,
    input  logic [spief_pkg::CLK_W-1:0]   i_divisor,
    output logic                          o_busy,
    output logic [spief_pkg::CLK_W-1:0]   o_quotient
);
    localparam int W   = spief_pkg::CLK_W;
    localparam int C_W = $clog2(W);

    logic [W-1:0]   r_rem, n_rem;
    logic [W-1:0]   r_quo, n_quo;
    logic [W-1:0]   r_dvs;
    logic [C_W-1:0] r_cnt;
    logic           r_busy;
    logic [W:0]     trial;
    logic [W:0]     diff;

    always_comb begin
        trial = {r_rem, r_quo[W-1]};
        diff  = trial - {1'b0, r_dvs};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = diff[W-1:0];
            n_quo = {r_quo[W-2:0], 1'b1};
        end else begin
            n_rem = trial[W-1:0];
            n_quo = {r_quo[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == C_W'(W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
endmodule

/* rtl/spi_engine_command_framer.sv */
// SPI engine command framer: microcoded sequencer turning requests into engine command bytes.
//
//  channel   dir  handshake          payload
//  i_req     in   valid/ready        func, cs_select, transfer_length, data_byte
//  o_rsp     out  valid/ready        cmd_byte, end_of_run, end_of_buffer, status
//  i_cfg_*   in   write enable only  index 0 clock_hz, 1 spi_mode, 2 tms_high
//
//  One program step per cycle, save that emitting steps wait while the output register
//  is full; each emitting step yields one response byte. A full setup adds a start step
//  and a wait on the one-bit-per-cycle divider. The first step runs in the cycle a
//  request is accepted. Synchronous reset restores the register defaults and closes any
//  transaction.
`timescale 1ns / 1ps
module spi_engine_command_framer #(
    parameter int CHUNK_MAX = 65530,
    parameter int LEN_BITS  = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    spief_stream_if.sink                 i_req,
    spief_stream_if.source               o_rsp,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [spief_pkg::CLK_W-1:0]  i_cfg_data
);
    localparam int TL_W = (LEN_BITS + 1 < spief_pkg::LEN_W) ? LEN_BITS + 1 : spief_pkg::LEN_W;
    localparam logic [32:0] LEN_CAP = 33'(1) << LEN_BITS;
    localparam int PW = spief_pkg::PC_W;
    localparam int CW = spief_pkg::CLK_W;

    function automatic logic [15:0] f_chunk(input logic [TL_W-1:0] left);
        if (32'(left) > 32'(CHUNK_MAX)) begin
            return 16'(CHUNK_MAX);
        end
        return 16'(left);
    endfunction

    // configuration
    logic [CW-1:0]   r_clk_hz;
    logic [1:0]      r_mode;
    logic            r_tms;

    // transaction state
    logic            r_busy;
    logic [1:0]      r_cs;
    logic [TL_W-1:0] r_total;
    logic [15:0]     r_chunk;

    // sequencer
    logic            r_idle;
    logic [PW-1:0]   r_pc, n_pc;
    logic [PW-1:0]   entry;
    logic [PW-1:0]   addr;
    spief_pkg::t_uword cw;
    logic            step;
    logic            jump;
    logic            accept;
    logic            out_free;

    // output register
    logic            r_ovalid;
    spief_pkg::t_rsp r_out, n_out;

    // datapath
    logic [TL_W-1:0] len_clamp;
    logic [TL_W-1:0] total_dec;
    logic [7:0]      port_val;
    logic [15:0]     hdr;
    logic            slow;
    logic [CW-1:0]   speed;
    logic            div_busy;
    logic [CW-1:0]   quo;
    logic [CW-1:0]   quo_m1;
    logic [15:0]     div_val;

    assign out_free    = !r_ovalid || o_rsp.ready;
    assign i_req.ready = r_idle && out_free;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        case (i_req.payload.func)
            spief_pkg::FUNC_START: begin
                if (r_busy) begin
                    entry = spief_pkg::PC_ERR_BUSY;
                end else if (i_req.payload.transfer_length == '0) begin
                    entry = spief_pkg::PC_ERR_ZERO;
                end else begin
                    entry = spief_pkg::PC_START;
                end
            end
            spief_pkg::FUNC_DATA: begin
                if (!r_busy) begin
                    entry = spief_pkg::PC_ERR_NOTX;
                end else if (r_total == TL_W'(1)) begin
                    entry = spief_pkg::PC_PAY_CLOSE;
                end else if (r_chunk == 16'd1) begin
                    entry = spief_pkg::PC_PAY_CHUNK;
                end else begin
                    entry = spief_pkg::PC_PAY_MID;
                end
            end
            spief_pkg::FUNC_SETUP: entry = spief_pkg::PC_SETUP;
            default:               entry = spief_pkg::PC_PORT_SETUP;
        endcase
    end

    assign addr = r_idle ? entry : r_pc;
    assign cw   = spief_pkg::f_rom(addr);
    assign step = r_idle ? accept : (!cw.emit || out_free);

    always_comb begin
        case (cw.jmp)
            spief_pkg::JMP_ALWAYS:   jump = 1'b1;
            spief_pkg::JMP_CLK_ZERO: jump = (r_clk_hz == '0);
            spief_pkg::JMP_DIV_BUSY: jump = div_busy;
            default:                 jump = 1'b0;
        endcase
        n_pc = jump ? cw.target : addr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle <= 1'b1;
            r_pc   <= '0;
        end else if (step) begin
            r_idle <= cw.last;
            r_pc   <= n_pc;
        end
    end

    // port byte: selects high, the open one low; TMS on bit 3; clock idle level on bit 0
    always_comb begin
        port_val = spief_pkg::PORT_IDLE;
        if (r_busy) begin
            port_val[4 + 32'(r_cs)] = 1'b0;
        end
        port_val[3] = r_tms;
        port_val[0] = r_mode[1];
    end

    assign hdr = r_chunk - 16'd1;

    always_comb begin
        if ({8'd0, i_req.payload.transfer_length} > LEN_CAP) begin
            len_clamp = LEN_CAP[TL_W-1:0];
        end else begin
            len_clamp = i_req.payload.transfer_length[TL_W-1:0];
        end
    end

    assign total_dec = r_total - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cs    <= '0;
            r_total <= '0;
            r_chunk <= '0;
        end else if (step) begin
            case (cw.op)
                spief_pkg::OP_START: begin
                    r_busy  <= 1'b1;
                    r_cs    <= i_req.payload.cs_select;
                    r_total <= len_clamp;
                    r_chunk <= f_chunk(len_clamp);
                end
                spief_pkg::OP_PAY: begin
                    r_total <= total_dec;
                    if (total_dec == '0) begin
                        r_busy  <= 1'b0;
                        r_chunk <= '0;
                    end else if (r_chunk == 16'd1) begin
                        r_chunk <= f_chunk(total_dec);
                    end else begin
                        r_chunk <= r_chunk - 16'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= spief_pkg::CLK_BASE;
            r_mode   <= 2'd1;
            r_tms    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                spief_pkg::CFG_CLOCK_HZ: r_clk_hz <= i_cfg_data;
                spief_pkg::CFG_SPI_MODE: r_mode   <= i_cfg_data[1:0];
                spief_pkg::CFG_TMS_HIGH: r_tms    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // clock divider
    assign slow  = (r_clk_hz <= spief_pkg::CLK_BASE);
    assign speed = (r_clk_hz > spief_pkg::CLK_FAST) ? spief_pkg::CLK_FAST : r_clk_hz;

    spief_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (step && cw.op == spief_pkg::OP_DIV),
        .i_dividend (slow ? spief_pkg::CLK_BASE : spief_pkg::CLK_FAST),
        .i_divisor  (speed),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );

    assign quo_m1 = quo - 1'b1;

    always_comb begin
        if (slow) begin
            div_val = (quo_m1 > CW'(16'hFFFF)) ? 16'hFFFF : quo_m1[15:0];
        end else if (speed < spief_pkg::CLK_FAST && quo_m1 == '0) begin
            div_val = 16'd1;
        end else begin
            div_val = quo_m1[15:0];
        end
    end

    // response byte
    always_comb begin
        n_out.end_of_run    = cw.last;
        n_out.end_of_buffer = cw.eob;
        n_out.status        = cw.status;
        case (cw.src)
            spief_pkg::SRC_DATA:   n_out.cmd_byte = i_req.payload.data_byte;
            spief_pkg::SRC_PORT:   n_out.cmd_byte = port_val;
            spief_pkg::SRC_HDR_LO: n_out.cmd_byte = hdr[7:0];
            spief_pkg::SRC_HDR_HI: n_out.cmd_byte = hdr[15:8];
            spief_pkg::SRC_CLKCMD: begin
                n_out.cmd_byte = slow ? spief_pkg::CMD_PRESC_ON : spief_pkg::CMD_PRESC_OFF;
            end
            spief_pkg::SRC_DIV_LO: n_out.cmd_byte = div_val[7:0];
            spief_pkg::SRC_DIV_HI: n_out.cmd_byte = div_val[15:8];
            default:               n_out.cmd_byte = cw.konst;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (step && cw.emit) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && cw.emit) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.payload = r_out;
endmodule
